// File: hw/rtl/assert_macros.svh
// ============================================================================
// assert_macros.svh
// Shared assertion macros for the pooling block. Every check is clocked and
// is switched off while the synchronous reset is held.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property check
`define MP2A_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition in this cycle implies property in the next cycle
`define MP2A_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
    `MP2A_ASSERT(lbl, clk, rst_n, (cond) |=> (prop), msg)

`endif

// File: hw/rtl/mp2a_pkg.sv
// ============================================================================
// mp2a_pkg
// Types and fixed constants of the 2D max pooling block with argmax.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mp2a_pkg;

    // Configuration register map
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 11;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_KERNEL_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_KERNEL_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_COUNT = 3'd4;

    // Register widths and reset values
    localparam int KSIZE_BITS = 4;
    localparam int ISIZE_BITS = 11;
    localparam int CCOUNT_BITS = 9;

    localparam logic [KSIZE_BITS-1:0]  RST_KERNEL_WIDTH  = 4'd2;
    localparam logic [KSIZE_BITS-1:0]  RST_KERNEL_HEIGHT = 4'd2;
    localparam logic [ISIZE_BITS-1:0]  RST_IMAGE_WIDTH   = 11'd28;
    localparam logic [ISIZE_BITS-1:0]  RST_IMAGE_HEIGHT  = 11'd28;
    localparam logic [CCOUNT_BITS-1:0] RST_CHANNEL_COUNT = 9'd1;

    localparam int MAX_CHANNELS = 256;

    // Result field widths
    localparam int POOL_BITS = 15;
    localparam int COL_BITS  = 10;
    localparam int ROW_BITS  = 10;
    localparam int CHAN_BITS = 8;
    localparam int OFS_BITS  = 3;

    // Stored argmax word: {valid, dy, dx}
    localparam int ARG_BITS = 2 * OFS_BITS + 1;

    typedef struct packed {
        logic [KSIZE_BITS-1:0]  kernel_width;
        logic [KSIZE_BITS-1:0]  kernel_height;
        logic [ISIZE_BITS-1:0]  image_width;
        logic [ISIZE_BITS-1:0]  image_height;
        logic [CCOUNT_BITS-1:0] channel_count;
    } t_cfg;

    // Per-sample control handed from the scan stage to the update stage
    typedef struct packed {
        logic                 first;
        logic                 emit;
        logic                 last;
        logic [OFS_BITS-1:0]  dx;
        logic [OFS_BITS-1:0]  dy;
        logic [COL_BITS-1:0]  col;
        logic [ROW_BITS-1:0]  row;
        logic [CHAN_BITS-1:0] chan;
    } t_scan_ctl;

    typedef struct packed {
        logic [POOL_BITS-1:0] pooled_value;
        logic [COL_BITS-1:0]  out_col;
        logic [ROW_BITS-1:0]  out_row;
        logic [CHAN_BITS-1:0] out_channel;
        logic [OFS_BITS-1:0]  argmax_dx;
        logic [OFS_BITS-1:0]  argmax_dy;
        logic                 argmax_valid;
        logic                 frame_last;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/mp2a_ram.sv
// ============================================================================
// mp2a_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// A read of the address being written returns the old contents.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mp2a_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// File: hw/rtl/mp2a_scan.sv
// ============================================================================
// mp2a_scan
// Raster position counters, window fit test and memory read issue. Each
// accepted sample that lies in a whole window moves on to the update stage.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mp2a_scan
    import mp2a_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_KERNEL  = 8,
    parameter int SAMPLE_BITS = 16,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_cfg                   i_cfg,
    input  wire logic                   i_accept,
    input  wire logic [SAMPLE_BITS-1:0] i_sample,
    output logic                        o_rd_en,
    output logic      [CW-1:0]          o_rd_addr,
    output logic                        o_b_valid,
    output t_scan_ctl                   o_b_ctl,
    output logic      [CW-1:0]          o_b_addr,
    output logic      [SAMPLE_BITS-1:0] o_b_sample
);

    localparam int KW  = $clog2(MAX_KERNEL + 1);
    localparam int KOW = $clog2(MAX_KERNEL);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int PW  = CW + KW + 1;

    // Effective (clamped) sizes
    logic [KW-1:0]          kw, kh;
    logic [WW-1:0]          w, h;
    logic [CCOUNT_BITS-1:0] c;

    // Raster counters
    logic [CW-1:0]        r_pix_col, n_pix_col;
    logic [CW-1:0]        r_pix_row, n_pix_row;
    logic [CHAN_BITS-1:0] r_chan, n_chan;
    logic [KOW-1:0]       r_wco, n_wco;
    logic [KOW-1:0]       r_wro, n_wro;
    logic [CW-1:0]        r_oc, n_oc;
    logic [CW-1:0]        r_or, n_or;

    // Window geometry
    logic [PW-1:0] col_prod, col_end, col_end2;
    logic [PW-1:0] row_prod, row_end, row_end2;
    logic          fits, col_done, row_done, chan_last;
    t_scan_ctl     ctl;

    // Stage register toward the update stage
    logic                   r_b_valid;
    t_scan_ctl              r_b_ctl;
    logic [CW-1:0]          r_b_addr;
    logic [SAMPLE_BITS-1:0] r_b_sample;

    // Clamp register values: zero counts as one, large values saturate
    always_comb begin
        if (i_cfg.kernel_width == '0) begin
            kw = KW'(1);
        end else if (int'(i_cfg.kernel_width) > MAX_KERNEL) begin
            kw = KW'(MAX_KERNEL);
        end else begin
            kw = KW'(i_cfg.kernel_width);
        end

        if (i_cfg.kernel_height == '0) begin
            kh = KW'(1);
        end else if (int'(i_cfg.kernel_height) > MAX_KERNEL) begin
            kh = KW'(MAX_KERNEL);
        end else begin
            kh = KW'(i_cfg.kernel_height);
        end

        if (i_cfg.image_width == '0) begin
            w = WW'(1);
        end else if (int'(i_cfg.image_width) > MAX_WIDTH) begin
            w = WW'(MAX_WIDTH);
        end else begin
            w = WW'(i_cfg.image_width);
        end

        if (i_cfg.image_height == '0) begin
            h = WW'(1);
        end else if (int'(i_cfg.image_height) > MAX_WIDTH) begin
            h = WW'(MAX_WIDTH);
        end else begin
            h = WW'(i_cfg.image_height);
        end

        if (i_cfg.channel_count == '0) begin
            c = CCOUNT_BITS'(1);
        end else if (int'(i_cfg.channel_count) > MAX_CHANNELS) begin
            c = CCOUNT_BITS'(MAX_CHANNELS);
        end else begin
            c = i_cfg.channel_count;
        end
    end

    // Window fit: (oc+1)*kw <= w; last window of the row: (oc+2)*kw > w
    always_comb begin
        col_prod = PW'(r_oc) * PW'(kw);
        col_end  = col_prod + PW'(kw);
        col_end2 = col_end + PW'(kw);
        row_prod = PW'(r_or) * PW'(kh);
        row_end  = row_prod + PW'(kh);
        row_end2 = row_end + PW'(kh);
    end

    assign fits      = (col_end <= PW'(w)) && (row_end <= PW'(h));
    assign col_done  = (KW'(r_wco) + KW'(1)) == kw;
    assign row_done  = (KW'(r_wro) + KW'(1)) == kh;
    assign chan_last = (CCOUNT_BITS'(r_chan) + CCOUNT_BITS'(1)) == c;

    // Control word for the update stage
    always_comb begin
        ctl.first = (r_wco == '0) && (r_wro == '0);
        ctl.emit  = col_done && row_done;
        ctl.last  = (col_end2 > PW'(w)) && (row_end2 > PW'(h)) && chan_last;
        ctl.dx    = OFS_BITS'(r_wco);
        ctl.dy    = OFS_BITS'(r_wro);
        ctl.col   = COL_BITS'(r_oc);
        ctl.row   = ROW_BITS'(r_or);
        ctl.chan  = r_chan;
    end

    // Read the partial entry of this output column
    assign o_rd_en   = i_accept && fits;
    assign o_rd_addr = r_oc;

    // Raster advance: columns, then rows, then channels
    always_comb begin
        n_pix_col = r_pix_col;
        n_pix_row = r_pix_row;
        n_chan    = r_chan;
        n_wco     = r_wco;
        n_wro     = r_wro;
        n_oc      = r_oc;
        n_or      = r_or;
        if (i_accept) begin
            if (WW'(r_pix_col) + WW'(1) >= w) begin
                n_pix_col = '0;
                n_wco     = '0;
                n_oc      = '0;
                if (WW'(r_pix_row) + WW'(1) >= h) begin
                    n_pix_row = '0;
                    n_wro     = '0;
                    n_or      = '0;
                    if (CCOUNT_BITS'(r_chan) + CCOUNT_BITS'(1) >= c) begin
                        n_chan = '0;
                    end else begin
                        n_chan = r_chan + CHAN_BITS'(1);
                    end
                end else begin
                    n_pix_row = r_pix_row + CW'(1);
                    if (KW'(r_wro) + KW'(1) >= kh) begin
                        n_wro = '0;
                        n_or  = r_or + CW'(1);
                    end else begin
                        n_wro = r_wro + KOW'(1);
                    end
                end
            end else begin
                n_pix_col = r_pix_col + CW'(1);
                if (KW'(r_wco) + KW'(1) >= kw) begin
                    n_wco = '0;
                    n_oc  = r_oc + CW'(1);
                end else begin
                    n_wco = r_wco + KOW'(1);
                end
            end
        end
    end

    // Counter and stage-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pix_col <= '0;
            r_pix_row <= '0;
            r_chan    <= '0;
            r_wco     <= '0;
            r_wro     <= '0;
            r_oc      <= '0;
            r_or      <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_pix_col <= n_pix_col;
            r_pix_row <= n_pix_row;
            r_chan    <= n_chan;
            r_wco     <= n_wco;
            r_wro     <= n_wro;
            r_oc      <= n_oc;
            r_or      <= n_or;
            r_b_valid <= i_accept && fits;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_b_ctl    <= ctl;
            r_b_addr   <= r_oc;
            r_b_sample <= i_sample;
        end
    end

    assign o_b_valid  = r_b_valid;
    assign o_b_ctl    = r_b_ctl;
    assign o_b_addr   = r_b_addr;
    assign o_b_sample = r_b_sample;

    `MP2A_ASSERT_NEXT(a_fit_sample_enters_update, i_clk, i_rst_n, i_accept && fits, r_b_valid && r_b_addr == $past(r_oc), "fitting sample did not reach update stage")

endmodule

`default_nettype wire

// File: hw/rtl/mp2a_update.sv
// ============================================================================
// mp2a_update
// Read-modify-write of the per-column partial max/argmax memory. Forwards the
// previous write when it hits the entry just read, and forms the result.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mp2a_update
    import mp2a_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int SAMPLE_BITS = 16,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_rd_en,
    input  wire logic [CW-1:0]          i_rd_addr,
    input  wire logic                   i_b_valid,
    input  wire t_scan_ctl              i_b_ctl,
    input  wire logic [CW-1:0]          i_b_addr,
    input  wire logic [SAMPLE_BITS-1:0] i_b_sample,
    output logic                        o_push,
    output t_result                     o_result
);

    // Maximum is never negative, so the sign bit is not stored
    localparam int MW = SAMPLE_BITS - 1;
    localparam int DW = MW + ARG_BITS;

    logic [DW-1:0]       rd_data, wr_data;
    logic [MW-1:0]       base_max, new_max;
    logic [ARG_BITS-1:0] base_arg, new_arg;
    logic                take;

    // Last write, for the read that was captured at the same edge
    logic          r_fw_valid;
    logic [CW-1:0] r_fw_addr;
    logic [DW-1:0] r_fw_data;

    mp2a_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_WIDTH)
    ) u_partial_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_b_valid),
        .i_wr_addr (i_b_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (rd_data)
    );

    // Running value: fresh window, forwarded write, or memory
    always_comb begin
        if (i_b_ctl.first) begin
            base_max = '0;
            base_arg = '0;
        end else if (r_fw_valid && (r_fw_addr == i_b_addr)) begin
            base_max = r_fw_data[MW-1:0];
            base_arg = r_fw_data[DW-1:MW];
        end else begin
            base_max = rd_data[MW-1:0];
            base_arg = rd_data[DW-1:MW];
        end
    end

    // Ties go to the later sample
    assign take    = !i_b_sample[SAMPLE_BITS-1] && (i_b_sample[MW-1:0] >= base_max);
    assign new_max = take ? i_b_sample[MW-1:0] : base_max;
    assign new_arg = take ? {1'b1, i_b_ctl.dy, i_b_ctl.dx} : base_arg;
    assign wr_data = {new_arg, new_max};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= i_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_b_valid) begin
            r_fw_addr <= i_b_addr;
            r_fw_data <= wr_data;
        end
    end

    // Result of a completed window
    always_comb begin
        o_result.pooled_value = POOL_BITS'(new_max);
        o_result.out_col      = i_b_ctl.col;
        o_result.out_row      = i_b_ctl.row;
        o_result.out_channel  = i_b_ctl.chan;
        o_result.argmax_dx    = new_arg[OFS_BITS-1:0];
        o_result.argmax_dy    = new_arg[2*OFS_BITS-1:OFS_BITS];
        o_result.argmax_valid = new_arg[ARG_BITS-1];
        o_result.frame_last   = i_b_ctl.last;
    end

    assign o_push = i_b_valid && i_b_ctl.emit;

    `MP2A_ASSERT_NEXT(a_write_captured_for_forward, i_clk, i_rst_n, i_b_valid, r_fw_valid && r_fw_addr == $past(i_b_addr), "forwarding register missed a write")

endmodule

`default_nettype wire

// File: hw/rtl/mp2a_outq.sv
// ============================================================================
// mp2a_outq
// Two-entry result queue. Gives credit to the input side so that a result in
// the update stage always finds a free slot.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mp2a_outq
    import mp2a_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_result,
    input  wire logic    i_out_ready,
    output logic         o_space,
    output logic         o_valid,
    output t_result      o_result
);

    t_result    r_q [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count, n_count;
    logic [2:0] reserved;
    logic       pop;

    assign o_valid  = r_count != 2'd0;
    assign o_result = r_q[r_rptr];
    assign pop      = o_valid && i_out_ready;

    // Entries held or about to be written, after this cycle's pop
    assign reserved = 3'(r_count) + 3'(i_push) - 3'(pop);
    assign o_space  = reserved < 3'd2;
    assign n_count  = 2'(reserved);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (pop) begin
                r_rptr <= !r_rptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_result;
        end
    end

    `MP2A_ASSERT(a_queue_credit, i_clk, i_rst_n, 3'(r_count) + 3'(i_push) <= 3'd2, "result queue overrun")

endmodule

`default_nettype wire

// File: hw/rtl/max_pool_2d_argmax.sv
// ============================================================================
// max_pool_2d_argmax
// Non-overlapping 2D max pooling with argmax over a raster sample stream.
// ============================================================================
// Usage:
//   Samples (signed Q8.8) arrive on the input request channel in raster
//   order: channel, then row, then column. One result request leaves per
//   completed window with the floored maximum, the window position, the
//   offset of the maximum inside the window and a last-of-frame flag.
//   Samples in partial windows at the right and bottom edges give nothing.
//   Throughput: one sample per cycle while input ready is high. The
//   per-column partial max and argmax live in one RAM that is read when a
//   sample is taken and written back in the following cycle; a forward path
//   covers back-to-back hits on the same column, so no bubble is needed.
//   A result passes the scan stage register and the result queue before it
//   is valid on the output.
//   A two-entry result queue decouples the output; when the receiver stalls,
//   input ready drops once the queue plus the update stage hold two results.
//   Reset clears counters, queue and registers (kernel 2x2, 28x28 image,
//   one channel); the partial RAM needs no clearing and input is taken as
//   soon as reset is released. Configuration writes are registered.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module max_pool_2d_argmax
    import mp2a_pkg::*;
#(
    parameter int MAX_WIDTH   = 1024,
    parameter int MAX_KERNEL  = 8,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Configuration write port
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  i_cfg_wdata,
    // Sample input
    input  wire logic                      i_in_valid,
    output logic                           o_in_ready,
    input  wire logic [SAMPLE_BITS-1:0]    i_sample,
    // Result output
    output logic                           o_out_valid,
    input  wire logic                      i_out_ready,
    output logic      [POOL_BITS-1:0]      o_pooled_value,
    output logic      [COL_BITS-1:0]       o_out_col,
    output logic      [ROW_BITS-1:0]       o_out_row,
    output logic      [CHAN_BITS-1:0]      o_out_channel,
    output logic      [OFS_BITS-1:0]       o_argmax_dx,
    output logic      [OFS_BITS-1:0]       o_argmax_dy,
    output logic                           o_argmax_valid,
    output logic                           o_frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);

    t_cfg                   r_cfg;
    logic                   accept;
    logic                   space;
    logic                   rd_en;
    logic [CW-1:0]          rd_addr;
    logic                   b_valid;
    t_scan_ctl              b_ctl;
    logic [CW-1:0]          b_addr;
    logic [SAMPLE_BITS-1:0] b_sample;
    logic                   push;
    t_result                result;
    t_result                out_result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kernel_width  <= RST_KERNEL_WIDTH;
            r_cfg.kernel_height <= RST_KERNEL_HEIGHT;
            r_cfg.image_width   <= RST_IMAGE_WIDTH;
            r_cfg.image_height  <= RST_IMAGE_HEIGHT;
            r_cfg.channel_count <= RST_CHANNEL_COUNT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_KERNEL_WIDTH:  r_cfg.kernel_width  <= i_cfg_wdata[KSIZE_BITS-1:0];
                CFG_KERNEL_HEIGHT: r_cfg.kernel_height <= i_cfg_wdata[KSIZE_BITS-1:0];
                CFG_IMAGE_WIDTH:   r_cfg.image_width   <= i_cfg_wdata[ISIZE_BITS-1:0];
                CFG_IMAGE_HEIGHT:  r_cfg.image_height  <= i_cfg_wdata[ISIZE_BITS-1:0];
                CFG_CHANNEL_COUNT: r_cfg.channel_count <= i_cfg_wdata[CCOUNT_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input handshake
    assign o_in_ready = i_rst_n && space;
    assign accept     = i_in_valid && o_in_ready;

    mp2a_scan #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_KERNEL  (MAX_KERNEL),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_scan (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_accept   (accept),
        .i_sample   (i_sample),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .o_b_valid  (b_valid),
        .o_b_ctl    (b_ctl),
        .o_b_addr   (b_addr),
        .o_b_sample (b_sample)
    );

    mp2a_update #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_update (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (rd_addr),
        .i_b_valid  (b_valid),
        .i_b_ctl    (b_ctl),
        .i_b_addr   (b_addr),
        .i_b_sample (b_sample),
        .o_push     (push),
        .o_result   (result)
    );

    mp2a_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_result    (result),
        .i_out_ready (i_out_ready),
        .o_space     (space),
        .o_valid     (o_out_valid),
        .o_result    (out_result)
    );

    // Result fields
    assign o_pooled_value = out_result.pooled_value;
    assign o_out_col      = out_result.out_col;
    assign o_out_row      = out_result.out_row;
    assign o_out_channel  = out_result.out_channel;
    assign o_argmax_dx    = out_result.argmax_dx;
    assign o_argmax_dy    = out_result.argmax_dy;
    assign o_argmax_valid = out_result.argmax_valid;
    assign o_frame_last   = out_result.frame_last;

endmodule

`default_nettype wire
